### hdl/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

  localparam int KeyW       = 32;
  localparam int ValW       = 32;
  localparam int CntW       = 32;
  localparam int ActW       = 5;
  localparam int EntriesDef = 16;

  localparam logic [ActW-1:0] ActiveReset = 5'd16;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic [CntW-1:0] count;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   vld;
    logic   le;
    logic   mv;
  } link_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_TOUCH  = 2'd1,
    MODE_INSERT = 2'd2
  } mode_e;

  typedef struct packed {
    logic   en;
    mode_e  mode;
    entry_t ent;
  } cell_cmd_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] cnt);
    sat_inc = (&cnt) ? cnt : cnt + CntW'(1);
  endfunction

endpackage

`default_nettype wire

### hdl/lfu_cache_lru_tiebreak_top.sv
// Key-value cache, least-frequently-used replacement with least-recent tie break, built
// as a row of ENTRIES cells kept in eviction order (head = next victim). Each request
// passes through a lookup state, in which every cell compares its key against the
// request, then an update state, in which the row shifts by one place and the touched
// or new entry drops into its slot. A new request is taken in the update cycle of the
// previous one, so a new request can enter before the last one is through. The result
// word is registered when the update cycle completes. A stall on the result side
// holds the block in its update cycle once the result register is full. hit_o flags a
// key that was present; read_value_o carries the stored value on a get hit, else zero.
// The capacity register is taken through the cfg channel (always ready), clamps at
// ENTRIES and resets to 16; zero makes every put a no-op.
`default_nettype none

module lfu_cache_lru_tiebreak_top #(
  parameter int ENTRIES = lfu_pkg::EntriesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lfu_pkg::ActW-1:0]      cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic signed [lfu_pkg::KeyW-1:0] lookup_key_i,
  input  wire logic signed [lfu_pkg::ValW-1:0] write_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               hit_o,
  output logic signed [lfu_pkg::ValW-1:0]    read_value_o
);
  import lfu_pkg::*;

  localparam int OccW = $clog2(ENTRIES + 1);
  localparam int CapW = (OccW > ActW) ? OccW : ActW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ActW-1:0] active_q;
  logic [OccW-1:0] occ_q;
  mode_e           mode_q, mode_d;
  logic [ENTRIES-1:0] pos_q, pos_d, aft_q, aft_d;

  logic            op_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] wval_q;
  entry_t          bus_q, bus_d;
  logic            res_hit_q;
  logic [ValW-1:0] res_val_q, res_val_d;

  logic            out_valid_q;
  logic            hit_q;
  logic [ValW-1:0] rval_q;

  logic               out_free;
  logic               in_accept;
  logic               upd_go;
  cell_cmd_t          cmd;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] aft_m;
  logic               hit;
  link_t              lk      [ENTRIES];
  link_t              left_lk [ENTRIES];
  link_t              right_lk[ENTRIES];
  logic [ValW-1:0]    sel_val;
  logic [CntW-1:0]    sel_cnt;
  logic [CapW-1:0]    act_ext;
  logic [CapW-1:0]    cap;
  logic               full;

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_UPD) && out_free));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign upd_go     = (state_q == ST_UPD) && out_free;

  assign cmd = '{en: upd_go, mode: mode_q, ent: bus_q};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    localparam logic [ENTRIES-1:0] LowMask = {ENTRIES{1'b1}} >> (ENTRIES - g);

    assign aft_m[g] = |(match & LowMask);

    if (g == 0) begin : g_first
      assign left_lk[g] = '{ent: '0, vld: 1'b0, le: 1'b1, mv: 1'b0};
    end else begin : g_mid_l
      assign left_lk[g] = lk[g-1];
    end

    if (g == ENTRIES - 1) begin : g_last
      assign right_lk[g] = '{ent: '0, vld: 1'b0, le: 1'b0, mv: 1'b0};
    end else begin : g_mid_r
      assign right_lk[g] = lk[g+1];
    end

    lfu_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .req_key_i(key_q),
      .pos_i    (pos_q[g]),
      .aft_i    (aft_q[g]),
      .left_i   (left_lk[g]),
      .right_i  (right_lk[g]),
      .link_o   (lk[g]),
      .match_o  (match[g])
    );
  end

  assign hit = |match;

  always_comb begin
    sel_val = '0;
    sel_cnt = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (match[j]) begin
        sel_val = sel_val | lk[j].ent.value;
        sel_cnt = sel_cnt | lk[j].ent.count;
      end
    end
  end

  assign act_ext = CapW'(active_q);
  assign cap     = (act_ext > CapW'(ENTRIES)) ? CapW'(ENTRIES) : act_ext;
  assign full    = CapW'(occ_q) >= cap;

  // decide the row operation for the update cycle
  always_comb begin
    bus_d.key   = key_q;
    bus_d.value = (op_q == OpPut) ? wval_q : sel_val;
    bus_d.count = hit ? sat_inc(sel_cnt) : CntW'(1);
    res_val_d   = ((op_q == OpGet) && hit) ? sel_val : '0;
    pos_d       = hit ? match : ENTRIES'(1);
    aft_d       = hit ? aft_m : ~ENTRIES'(1);
    mode_d      = MODE_NONE;
    if (op_q == OpGet) begin
      if (hit) begin
        mode_d = MODE_TOUCH;
      end
    end else if (active_q != '0) begin
      if (hit || full) begin
        mode_d = MODE_TOUCH;
      end else begin
        mode_d = MODE_INSERT;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          state_d = in_accept ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= ActiveReset;
      occ_q       <= '0;
      mode_q      <= MODE_NONE;
      pos_q       <= '0;
      aft_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
      if (state_q == ST_LOOK) begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        aft_q  <= aft_d;
      end
      if (upd_go && (mode_q == MODE_INSERT)) begin
        occ_q <= occ_q + OccW'(1);
      end
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= opcode_i;
      key_q  <= lookup_key_i;
      wval_q <= write_value_i;
    end
    if (state_q == ST_LOOK) begin
      bus_q     <= bus_d;
      res_hit_q <= hit;
      res_val_q <= res_val_d;
    end
    if (upd_go) begin
      hit_q  <= res_hit_q;
      rval_q <= res_val_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rval_q;

endmodule

`default_nettype wire

### hdl/lfu_cell.sv
`default_nettype none

module lfu_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lfu_pkg::cell_cmd_t      cmd_i,
  input  wire logic [lfu_pkg::KeyW-1:0] req_key_i,
  input  wire logic                    pos_i,
  input  wire logic                    aft_i,
  input  wire lfu_pkg::link_t          left_i,
  input  wire lfu_pkg::link_t          right_i,
  output lfu_pkg::link_t               link_o,
  output logic                         match_o
);
  import lfu_pkg::*;

  entry_t ent_q, ent_d;
  logic   vld_q, vld_d;
  logic   le;
  logic   mv;

  assign le      = vld_q && (ent_q.count <= cmd_i.ent.count);
  assign mv      = aft_i && le;
  assign match_o = vld_q && (ent_q.key == req_key_i);
  assign link_o  = '{ent: ent_q, vld: vld_q, le: le, mv: mv};

  always_comb begin
    ent_d = ent_q;
    vld_d = vld_q;
    if (cmd_i.en) begin
      case (cmd_i.mode)
        MODE_TOUCH: begin
          if (pos_i || mv) begin
            ent_d = right_i.mv ? right_i.ent : cmd_i.ent;
          end
        end
        MODE_INSERT: begin
          if (!le) begin
            if (left_i.le) begin
              ent_d = cmd_i.ent;
              vld_d = 1'b1;
            end else begin
              ent_d = left_i.ent;
              vld_d = left_i.vld;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire
